/* sv/csvfs_pkg.sv */
// ----------------------------------------------------------------------------
// csvfs_pkg
// Shared types and constants of the CSV field splitter: parse modes,
// configuration register indexes, reset values and the result record.
// ----------------------------------------------------------------------------
package csvfs_pkg;

    // byte and field widths
    localparam int BYTE_W      = 8;
    localparam int LIMIT_W     = 11;
    localparam int COL_IDX_W   = 10;
    localparam int CNT_W       = 32;
    localparam int CFG_IDX_W   = 2;

    // column saturation default
    localparam int MAX_COLUMNS_DEF = 1024;

    // row terminators
    localparam logic [BYTE_W-1:0] CH_CR = 8'd13;
    localparam logic [BYTE_W-1:0] CH_LF = 8'd10;

    // configuration reset values
    localparam logic [BYTE_W-1:0]  DELIMITER_RST    = 8'd44;
    localparam logic [BYTE_W-1:0]  QUOTE_CHAR_RST   = 8'd34;
    localparam logic [BYTE_W-1:0]  ESCAPE_CHAR_RST  = 8'd92;
    localparam logic [LIMIT_W-1:0] COLUMN_LIMIT_RST = 11'd16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELIMITER    = 2'd0,
        REG_QUOTE_CHAR   = 2'd1,
        REG_ESCAPE_CHAR  = 2'd2,
        REG_COLUMN_LIMIT = 2'd3
    } csvfs_reg_idx_t;

    // parse modes
    typedef enum logic [2:0] {
        MODE_START     = 3'd0,
        MODE_UNQ       = 3'd1,
        MODE_UNQ_ESC   = 3'd2,
        MODE_QUO       = 3'd3,
        MODE_QUO_AFTER = 3'd4,
        MODE_QUO_ESC   = 3'd5
    } csvfs_mode_t;

    // configuration seen by the parser
    typedef struct packed {
        logic [BYTE_W-1:0]  delimiter;
        logic [BYTE_W-1:0]  quote_char;
        logic [BYTE_W-1:0]  escape_char;
        logic [LIMIT_W-1:0] column_limit;
    } csvfs_cfg_t;

    // one finished cell
    typedef struct packed {
        logic [COL_IDX_W-1:0] column_index;
        logic [CNT_W-1:0]     cell_offset;
        logic [CNT_W-1:0]     cell_length;
        logic                 row_end;
        logic                 column_overflow;
        logic [CNT_W-1:0]     row_number;
    } csvfs_result_t;

endpackage

/* sv/csvfs_core.sv */
// ----------------------------------------------------------------------------
// csvfs_core
// Parser state machine: holds mode, stream position, cell start, column and
// row counters, and classifies one byte per step into a cell record.
// ----------------------------------------------------------------------------
module csvfs_core #(
    parameter int MAX_COLUMNS = csvfs_pkg::MAX_COLUMNS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [csvfs_pkg::BYTE_W-1:0]  data_byte,
    input  csvfs_pkg::csvfs_cfg_t         cfg,
    output logic                          emit,
    output csvfs_pkg::csvfs_result_t      result
);

    // saturating column counter sizing
    localparam int COL_COUNT = (MAX_COLUMNS > 1024) ? 1024 : MAX_COLUMNS;
    localparam int COL_W     = (COL_COUNT > 1) ? $clog2(COL_COUNT) : 1;
    localparam logic [COL_W-1:0] COL_SAT = COL_W'(COL_COUNT - 1);

    csvfs_pkg::csvfs_mode_t             mode_reg, mode_next;
    logic [csvfs_pkg::CNT_W-1:0]        pos_reg, pos_next;
    logic [csvfs_pkg::CNT_W-1:0]        start_reg, start_next;
    logic [COL_W-1:0]                   col_reg, col_next;
    logic [csvfs_pkg::CNT_W-1:0]        rows_reg, rows_next;

    logic                               is_nl;
    logic                               is_delim;
    logic                               is_quote;
    logic                               is_escape;
    logic                               row_end;
    logic                               drop_quote;
    logic                               at_start;
    logic [csvfs_pkg::CNT_W-1:0]        cell_len;

    // byte classification
    assign is_nl     = (data_byte == csvfs_pkg::CH_CR) || (data_byte == csvfs_pkg::CH_LF);
    assign is_delim  = (data_byte == cfg.delimiter);
    assign is_quote  = (data_byte == cfg.quote_char);
    assign is_escape = (data_byte == cfg.escape_char);

    // output decode: does this byte close a cell
    always_comb
    begin
        emit       = 1'b0;
        row_end    = 1'b0;
        drop_quote = 1'b0;
        at_start   = 1'b0;
        case (mode_reg)
            csvfs_pkg::MODE_UNQ:
            begin
                if (is_delim)
                begin
                    emit = 1'b1;
                end
                else if (is_nl)
                begin
                    emit    = 1'b1;
                    row_end = 1'b1;
                end
            end
            csvfs_pkg::MODE_QUO_AFTER:
            begin
                drop_quote = 1'b1;
                if (is_delim)
                begin
                    emit = 1'b1;
                end
                else if (is_nl)
                begin
                    emit    = 1'b1;
                    row_end = 1'b1;
                end
            end
            csvfs_pkg::MODE_UNQ_ESC,
            csvfs_pkg::MODE_QUO,
            csvfs_pkg::MODE_QUO_ESC:
            begin
                emit = 1'b0;
            end
            default:
            begin
                at_start = 1'b1;
                if (is_nl)
                begin
                    emit    = 1'b1;
                    row_end = 1'b1;
                end
                else if (!is_quote && is_delim)
                begin
                    emit = 1'b1;
                end
            end
        endcase
    end

    // cell length, closing quote left out
    assign cell_len = at_start ? '0
                    : (pos_reg - start_reg - csvfs_pkg::CNT_W'(drop_quote));

    // result record
    always_comb
    begin
        result.column_index    = csvfs_pkg::COL_IDX_W'(col_reg);
        result.cell_offset     = at_start ? pos_reg : start_reg;
        result.cell_length     = cell_len;
        result.row_end         = row_end;
        result.column_overflow = (csvfs_pkg::LIMIT_W'(col_reg) >= cfg.column_limit);
        result.row_number      = rows_reg;
    end

    // next state
    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        col_next   = col_reg;
        rows_next  = rows_reg;
        if (step)
        begin
            pos_next = pos_reg + 1'b1;
            case (mode_reg)
                csvfs_pkg::MODE_UNQ:
                begin
                    if (!is_delim && !is_nl && is_escape)
                    begin
                        mode_next = csvfs_pkg::MODE_UNQ_ESC;
                    end
                end
                csvfs_pkg::MODE_UNQ_ESC:
                begin
                    mode_next = csvfs_pkg::MODE_UNQ;
                end
                csvfs_pkg::MODE_QUO:
                begin
                    if (is_quote)
                    begin
                        mode_next = csvfs_pkg::MODE_QUO_AFTER;
                    end
                    else if (is_escape)
                    begin
                        mode_next = csvfs_pkg::MODE_QUO_ESC;
                    end
                end
                csvfs_pkg::MODE_QUO_ESC:
                begin
                    mode_next = csvfs_pkg::MODE_QUO;
                end
                csvfs_pkg::MODE_QUO_AFTER:
                begin
                    mode_next = csvfs_pkg::MODE_QUO;
                end
                default:
                begin
                    start_next = pos_reg;
                    if (is_nl)
                    begin
                        mode_next = csvfs_pkg::MODE_START;
                    end
                    else if (is_quote)
                    begin
                        start_next = pos_reg + 1'b1;
                        mode_next  = csvfs_pkg::MODE_QUO;
                    end
                    else if (is_delim)
                    begin
                        mode_next = csvfs_pkg::MODE_START;
                    end
                    else if (is_escape)
                    begin
                        mode_next = csvfs_pkg::MODE_UNQ_ESC;
                    end
                    else
                    begin
                        mode_next = csvfs_pkg::MODE_UNQ;
                    end
                end
            endcase

            // a finished cell returns to cell start and moves the counters
            if (emit)
            begin
                mode_next = csvfs_pkg::MODE_START;
                if (row_end)
                begin
                    col_next  = '0;
                    rows_next = rows_reg + 1'b1;
                end
                else if (col_reg < COL_SAT)
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= csvfs_pkg::MODE_START;
            pos_reg   <= '0;
            start_reg <= '0;
            col_reg   <= '0;
            rows_reg  <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            col_reg   <= col_next;
            rows_reg  <= rows_next;
        end
    end

`ifndef SYNTH
    // every processed byte advances the stream position by one
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (pos_reg == $past(pos_reg) + 1'b1))
        else $error("stream position did not advance");

    // a row end restarts the column and counts the row
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && emit && row_end) |=> ((col_reg == '0) &&
                                       (rows_reg == $past(rows_reg) + 1'b1)))
        else $error("row end did not update column and row counters");

    // a finished cell always leaves the parser at cell start
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && emit) |=> (mode_reg == csvfs_pkg::MODE_START))
        else $error("parser not at cell start after a cell");
`endif

endmodule

/* sv/csv_field_splitter.sv */
// ----------------------------------------------------------------------------
// csv_field_splitter
// Splits a CSV byte stream into cell records: column, offset, length,
// row end, column overflow and row number.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel data_valid/data_ready carries one stream byte per transfer.
//   Result channel result_valid/result_ready carries one record for each
//   byte that closes a cell (delimiter, CR or LF outside a quote or escape).
//   Configuration channel cfg_valid/cfg_ready (always ready) writes
//   delimiter, quote, escape and column limit; write only while idle.
//   Path: the byte that closes a cell is registered in the input stage, and
//   its record is registered in the result register.
//   Throughput: one byte per cycle; the input stage and the result register
//   part the two sides, so a byte that closes no cell is consumed even while
//   a record waits. The parser state update is a single registered step.
//   When the receiver stalls, a byte that would close a cell waits in the
//   input stage and data_ready drops until the result register frees.
//   Reset clears the parser to cell start, the position, column and row
//   counters to zero, and loads the default configuration (comma, double
//   quote, backslash, 16 columns).
// ----------------------------------------------------------------------------
module csv_field_splitter #(
    parameter int MAX_COLUMNS = csvfs_pkg::MAX_COLUMNS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // byte stream
    input  logic                              data_valid,
    output logic                              data_ready,
    input  logic [csvfs_pkg::BYTE_W-1:0]      data_byte,
    // cell records
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [csvfs_pkg::COL_IDX_W-1:0]   column_index,
    output logic [csvfs_pkg::CNT_W-1:0]       cell_offset,
    output logic [csvfs_pkg::CNT_W-1:0]       cell_length,
    output logic                              row_end,
    output logic                              column_overflow,
    output logic [csvfs_pkg::CNT_W-1:0]       row_number,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [csvfs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [csvfs_pkg::LIMIT_W-1:0]     cfg_data
);

    csvfs_pkg::csvfs_cfg_t             cfg_reg, cfg_next;
    logic                              in_vld_reg, in_vld_next;
    logic [csvfs_pkg::BYTE_W-1:0]      in_byte_reg, in_byte_next;
    logic                              out_vld_reg, out_vld_next;
    csvfs_pkg::csvfs_result_t          out_reg, out_next;

    logic                              step;
    logic                              emit;
    logic                              out_free;
    csvfs_pkg::csvfs_result_t          step_result;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (csvfs_pkg::csvfs_reg_idx_t'(cfg_index))
                csvfs_pkg::REG_DELIMITER:    cfg_next.delimiter    = cfg_data[7:0];
                csvfs_pkg::REG_QUOTE_CHAR:   cfg_next.quote_char   = cfg_data[7:0];
                csvfs_pkg::REG_ESCAPE_CHAR:  cfg_next.escape_char  = cfg_data[7:0];
                csvfs_pkg::REG_COLUMN_LIMIT: cfg_next.column_limit = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    // parser core
    csvfs_core #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .cfg       (cfg_reg),
        .emit      (emit),
        .result    (step_result)
    );

    // a held byte is processed when it closes no cell or the result slot frees
    assign out_free   = !out_vld_reg || result_ready;
    assign step       = in_vld_reg && (!emit || out_free);
    assign data_ready = !in_vld_reg || step;

    // input stage
    always_comb
    begin
        in_vld_next  = in_vld_reg;
        in_byte_next = in_byte_reg;
        if (data_valid && data_ready)
        begin
            in_vld_next  = 1'b1;
            in_byte_next = data_byte;
        end
        else if (step)
        begin
            in_vld_next = 1'b0;
        end
    end

    // result register
    always_comb
    begin
        out_vld_next = out_vld_reg;
        out_next     = out_reg;
        if (step && emit)
        begin
            out_vld_next = 1'b1;
            out_next     = step_result;
        end
        else if (result_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delimiter    <= csvfs_pkg::DELIMITER_RST;
            cfg_reg.quote_char   <= csvfs_pkg::QUOTE_CHAR_RST;
            cfg_reg.escape_char  <= csvfs_pkg::ESCAPE_CHAR_RST;
            cfg_reg.column_limit <= csvfs_pkg::COLUMN_LIMIT_RST;
            in_vld_reg           <= 1'b0;
            out_vld_reg          <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        out_reg     <= out_next;
    end

    // result ports
    assign result_valid    = out_vld_reg;
    assign column_index    = out_reg.column_index;
    assign cell_offset     = out_reg.cell_offset;
    assign cell_length     = out_reg.cell_length;
    assign row_end         = out_reg.row_end;
    assign column_overflow = out_reg.column_overflow;
    assign row_number      = out_reg.row_number;

`ifndef SYNTH
    // back pressure only while a byte is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !data_ready |-> in_vld_reg)
        else $error("input stalled with an empty input stage");

    // a closing byte blocked by a full result slot stays in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && emit && !out_free) |=> (in_vld_reg && $stable(in_byte_reg)))
        else $error("blocked closing byte was lost");

    // a processed closing byte shows up as a record next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && emit) |=> result_valid)
        else $error("finished cell did not reach the result register");
`endif

endmodule
